/* hw/rtl/qes_pkg.sv */
package qes_pkg;

  // Input command codes.
  localparam int unsigned CmdW = 2;
  localparam logic [CmdW-1:0] CMD_EDGE_A = 2'd0;
  localparam logic [CmdW-1:0] CMD_EDGE_B = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd2;

  // Configuration register indexes and data width.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_SCALE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DISTANCE_SCALE = 2'd1;

  localparam int unsigned SpeedScaleW = 16;
  localparam int unsigned DistScaleW  = 24;
  localparam logic [SpeedScaleW-1:0] SPEED_SCALE_RST = 16'd4404;
  localparam logic [DistScaleW-1:0]  DIST_SCALE_RST  = 24'd13841;

  localparam int unsigned CountW = 16;
  localparam int unsigned DeltaW = CountW + 1;
  localparam int unsigned SpeedW = 32;
  localparam int unsigned DistW  = 48;

  // Shared multiplier: signed operand times unsigned scale.
  localparam int unsigned MulAW = SpeedW + 1;
  localparam int unsigned MulBW = DistScaleW;
  localparam int unsigned MulPW = MulAW + MulBW + 1;

  // Dead band applied to the left wheel delta.
  localparam logic signed [DeltaW-1:0] PULL = 17'sd3;

  // Distance increment rounding: Q16.16 times Q0.24 back to Q16.16.
  localparam int unsigned DistShift = 24;

endpackage

/* hw/rtl/qes_ram.sv */
module qes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/qes_mul.sv */
module qes_mul (
  input  logic                               clk_i,
  input  logic signed [qes_pkg::MulAW-1:0]   a_i,
  input  logic        [qes_pkg::MulBW-1:0]   b_i,
  output logic signed [qes_pkg::MulPW-1:0]   prod_o
);

  logic signed [qes_pkg::MulPW-1:0] prod_d;

  // The scale is unsigned, so it is zero extended before the signed product.
  assign prod_d = qes_pkg::MulPW'(a_i) * qes_pkg::MulPW'($signed({1'b0, b_i}));

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
  end

endmodule

/* hw/rtl/quadrature_encoder_speed_estimator.sv */
// Two-wheel quadrature encoder speed estimator. Edge commands (encoder A or B)
// update the wheel counters in the cycle they are accepted and produce no
// result. A sample tick produces one result transaction: while the delay line
// is still filling it goes straight to the done state and the output register,
// and once the line holds WINDOW samples a short sequencer reads the history
// memory, then runs the left speed, the right speed and the distance increment
// one after another through a single registered multiplier.
// The input stalls while a tick is being processed; a finished result waits in
// the output register so the next item can be accepted meanwhile. Speeds are
// Q16.16 and the accumulated distance is Q32.16 and wraps.
module quadrature_encoder_speed_estimator #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [qes_pkg::CmdW-1:0]             command_i,
  input  logic                                 other_phase_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [qes_pkg::SpeedW-1:0]    speed_left_o,
  output logic signed [qes_pkg::SpeedW-1:0]    speed_right_o,
  output logic signed [qes_pkg::SpeedW-1:0]    speed_average_o,
  output logic signed [qes_pkg::DistW-1:0]     distance_total_o,
  output logic                                 window_full_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qes_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [qes_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int unsigned AddrW = $clog2(WINDOW);
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned CW    = qes_pkg::CountW;
  localparam int unsigned DW    = qes_pkg::DeltaW;
  localparam int unsigned SW    = qes_pkg::SpeedW;
  localparam int unsigned PW    = qes_pkg::MulPW;
  localparam int unsigned IncW  = PW - qes_pkg::DistShift;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_MULL = 4'd2;
  localparam logic [3:0] ST_MULR = 4'd3;
  localparam logic [3:0] ST_GETR = 4'd4;
  localparam logic [3:0] ST_AVG  = 4'd5;
  localparam logic [3:0] ST_MULD = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  logic [qes_pkg::SpeedScaleW-1:0] speed_scale_q;
  logic [qes_pkg::DistScaleW-1:0]  dist_scale_q;
  logic [CW-1:0]    count_l_q, count_r_q;
  logic [FillW-1:0] fill_q;
  logic [AddrW-1:0] slot_q;
  logic signed [qes_pkg::DistW-1:0] dist_q;

  logic signed [DW-1:0] delta_l_q, delta_r_q;
  logic signed [DW-1:0] delta_l_d, delta_r_d;
  logic signed [SW-1:0] left_q, right_q, avg_q;
  logic                 full_q;

  logic                 out_valid_q;
  logic                 out_free;
  logic                 in_acc;

  logic                 ram_we;
  logic [2*CW-1:0]      ram_rdata;
  logic [AddrW-1:0]     slot_next;

  logic signed [qes_pkg::MulAW-1:0] mul_a;
  logic        [qes_pkg::MulBW-1:0] mul_b;
  logic signed [PW-1:0]             mul_p;

  logic signed [SW-1:0] prod_clamped;
  logic signed [SW:0]   avg_sum;
  logic signed [PW-1:0] dist_round;
  logic signed [IncW-1:0] dist_inc;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign slot_next = (slot_q == AddrW'(WINDOW - 1)) ? '0 : slot_q + AddrW'(1);

  qes_ram #(
    .Width (2 * CW),
    .Depth (WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({count_l_q, count_r_q}),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  qes_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  // Window deltas with the left wheel's inverted sense and dead band.
  always_comb begin
    logic [CW-1:0]        dl, dr;
    logic signed [DW-1:0] t;
    dl = count_l_q - ram_rdata[2*CW-1:CW];
    dr = count_r_q - ram_rdata[CW-1:0];
    t  = -DW'($signed(dl));
    if (t > qes_pkg::PULL) begin
      t = t - qes_pkg::PULL;
    end else if (t < -qes_pkg::PULL) begin
      t = t + qes_pkg::PULL;
    end
    delta_l_d = t;
    delta_r_d = DW'($signed(dr));
  end

  always_comb begin
    unique case (state_q)
      ST_MULL: begin
        mul_a = qes_pkg::MulAW'(delta_l_q);
        mul_b = qes_pkg::MulBW'(speed_scale_q);
      end
      ST_MULR: begin
        mul_a = qes_pkg::MulAW'(delta_r_q);
        mul_b = qes_pkg::MulBW'(speed_scale_q);
      end
      default: begin
        mul_a = qes_pkg::MulAW'(avg_q);
        mul_b = dist_scale_q;
      end
    endcase
  end

  always_comb begin
    if (mul_p > PW'(64'sh7FFF_FFFF)) begin
      prod_clamped = {1'b0, {(SW-1){1'b1}}};
    end else if (mul_p < -PW'(64'sh8000_0000)) begin
      prod_clamped = {1'b1, {(SW-1){1'b0}}};
    end else begin
      prod_clamped = mul_p[SW-1:0];
    end
  end

  assign avg_sum    = {left_q[SW-1], left_q} + {right_q[SW-1], right_q};
  assign dist_round = mul_p + (PW'(1) <<< (qes_pkg::DistShift - 1));
  assign dist_inc   = dist_round[PW-1:qes_pkg::DistShift];

  always_comb begin
    state_d = state_q;
    ram_we  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && command_i == qes_pkg::CMD_TICK) begin
          if (fill_q == FillW'(WINDOW)) begin
            state_d = ST_READ;
          end else begin
            ram_we  = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        ram_we  = 1'b1;
        state_d = ST_MULL;
      end
      ST_MULL: state_d = ST_MULR;
      ST_MULR: state_d = ST_GETR;
      ST_GETR: state_d = ST_AVG;
      ST_AVG:  state_d = ST_MULD;
      ST_MULD: state_d = ST_ACC;
      ST_ACC:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      speed_scale_q <= qes_pkg::SPEED_SCALE_RST;
      dist_scale_q  <= qes_pkg::DIST_SCALE_RST;
      count_l_q     <= '0;
      count_r_q     <= '0;
      fill_q        <= '0;
      slot_q        <= '0;
      dist_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        if (cfg_index_i == qes_pkg::CFG_SPEED_SCALE) begin
          speed_scale_q <= cfg_data_i[qes_pkg::SpeedScaleW-1:0];
        end else if (cfg_index_i == qes_pkg::CFG_DISTANCE_SCALE) begin
          dist_scale_q <= cfg_data_i[qes_pkg::DistScaleW-1:0];
        end
      end

      if (in_acc && command_i == qes_pkg::CMD_EDGE_A) begin
        count_l_q <= other_phase_i ? count_l_q - CW'(1) : count_l_q + CW'(1);
      end
      if (in_acc && command_i == qes_pkg::CMD_EDGE_B) begin
        count_r_q <= other_phase_i ? count_r_q + CW'(1) : count_r_q - CW'(1);
      end

      if (ram_we) begin
        slot_q <= slot_next;
        if (state_q == ST_IDLE) begin
          fill_q <= fill_q + FillW'(1);
        end
      end

      if (state_q == ST_ACC) begin
        dist_q <= dist_q + qes_pkg::DistW'(dist_inc);
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; the sequencer decides when each one is meaningful.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      left_q  <= '0;
      right_q <= '0;
      avg_q   <= '0;
      full_q  <= 1'b0;
    end
    if (state_q == ST_READ) begin
      delta_l_q <= delta_l_d;
      delta_r_q <= delta_r_d;
      full_q    <= 1'b1;
    end
    if (state_q == ST_MULR) begin
      left_q <= prod_clamped;
    end
    if (state_q == ST_GETR) begin
      right_q <= prod_clamped;
    end
    if (state_q == ST_AVG) begin
      avg_q <= avg_sum[SW:1];
    end
    if (state_q == ST_DONE && out_free) begin
      speed_left_o     <= left_q;
      speed_right_o    <= right_q;
      speed_average_o  <= avg_q;
      distance_total_o <= dist_q;
      window_full_o    <= full_q;
    end
  end

endmodule
